// ----- design/i2c_master_register_transfer_assert.svh -----
// ----------------------------------------------------------------------------
// I2C register transfer assertion macros
// Assertion helpers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`ifndef SYNTHESIS
`define IMRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define IMRT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define IMRT_ASSERT(label, clk, rst_n, prop)
`define IMRT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- design/imrt_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register transfer package
// Shared types, codes and constants of the I2C register transfer master.
// ----------------------------------------------------------------------------
package imrt_pkg;

  localparam int unsigned WriteBufferDepth = 32;
  localparam int unsigned BufAw = $clog2(WriteBufferDepth);
  localparam int unsigned FillW = $clog2(WriteBufferDepth + 1);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_BUS_BUSY = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_ARB_LOST = 3'd4,
    ST_NO_ACK   = 3'd5,
    ST_BAD_LEN  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_ADDR_W  = 3'd0,
    PH_OFF_LO  = 3'd1,
    PH_OFF_HI  = 3'd2,
    PH_DATA    = 3'd3,
    PH_RESTART = 3'd4,
    PH_ADDR_R  = 3'd5,
    PH_RX      = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_HALF     = 3'd1,
    REG_STRETCH  = 3'd2,
    REG_RSTRETCH = 3'd3,
    REG_FREE     = 3'd4
  } reg_e;

  typedef enum logic [18:0] {
    SQ_IDLE       = 19'h00001,
    SQ_FREE_WAIT  = 19'h00002,
    SQ_FREE_COUNT = 19'h00004,
    SQ_START_HOLD = 19'h00008,
    SQ_TX_LOW     = 19'h00010,
    SQ_TX_RISE    = 19'h00020,
    SQ_TX_HIGH    = 19'h00040,
    SQ_ACK_LOW    = 19'h00080,
    SQ_ACK_RISE   = 19'h00100,
    SQ_ACK_HIGH   = 19'h00200,
    SQ_RX_LOW     = 19'h00400,
    SQ_RX_RISE    = 19'h00800,
    SQ_RX_HIGH    = 19'h01000,
    SQ_MACK_LOW   = 19'h02000,
    SQ_MACK_RISE  = 19'h04000,
    SQ_MACK_HIGH  = 19'h08000,
    SQ_STOP_LOW   = 19'h10000,
    SQ_STOP_RISE  = 19'h20000,
    SQ_STOP_HIGH  = 19'h40000
  } seq_e;

  typedef struct packed {
    logic [1:0]  func;
    logic        scl_in;
    logic        sda_in;
    logic        is_read;
    logic [6:0]  slave_addr;
    logic [15:0] reg_offset;
    logic [7:0]  byte_count;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        read_last;
    logic        done_res;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] half_period_ticks;
    logic [15:0] stretch_timeout;
    logic [15:0] receive_stretch_timeout;
    logic [7:0]  bus_free_ticks;
  } cfg_t;

endpackage

// ----- design/imrt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module imrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/imrt_front.sv -----
// ----------------------------------------------------------------------------
// I2C register transfer front end
// Accepts input words into a short queue that decouples the bus engine.
// ----------------------------------------------------------------------------
module imrt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  imrt_pkg::in_word_t  in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output imrt_pkg::in_word_t  q_data_o
);

  imrt_pkg::in_word_t slot_q [imrt_pkg::QueueDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = slot_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/imrt_engine.sv -----
// ----------------------------------------------------------------------------
// I2C register transfer bus engine
// Runs the bus sequence one word per cycle unless stalled; holds the result.
// ----------------------------------------------------------------------------
module imrt_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imrt_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  imrt_pkg::in_word_t  q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imrt_pkg::out_word_t out_data_o
);

  localparam int unsigned Aw = imrt_pkg::BufAw;
  localparam int unsigned Fw = imrt_pkg::FillW;

  imrt_pkg::seq_e   seq_q, seq_d;
  imrt_pkg::phase_e ph_q, ph_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  sh_q, sh_d;
  logic [15:0] hp_q, hp_d, to_q, to_d;
  logic [7:0]  rem_q, rem_d;
  logic [6:0]  addr_q, addr_d;
  logic [15:0] off_q, off_d;
  logic        rd_q, rd_d;
  logic [Fw-1:0] fill_q, fill_d, ridx_q, ridx_d;
  logic [2:0]  pend_q, pend_d;
  logic        nak_q, nak_d;
  logic        outv_q;
  imrt_pkg::out_word_t res_q, res_d;
  logic        ram_we;
  logic [7:0]  ram_rd;
  logic [15:0] hp_inc, to_inc;
  logic        half_done;
  logic        step;
  logic        bitv;
  logic        go;
  logic        finish;
  logic [2:0]  fin_st;

  // Next buffer word is prefetched from ridx_q into the registered ram_rd.
  imrt_ram #(.Width(8), .Depth(imrt_pkg::WriteBufferDepth)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[Aw-1:0]),
    .wdata_i (q_data_i.write_byte),
    .raddr_i (ridx_q[Aw-1:0]),
    .rdata_o (ram_rd)
  );

  assign q_ready_o   = !outv_q || out_ready_i;
  assign step        = q_valid_i && q_ready_o;
  assign out_valid_o = outv_q;
  assign out_data_o  = res_q;
  assign hp_inc      = hp_q + 16'd1;
  assign to_inc      = to_q + 16'd1;
  assign half_done   = (hp_inc >= cfg_i.half_period_ticks);
  assign bitv        = sh_q[7];
  assign ram_we = step && (q_data_i.func == imrt_pkg::FUNC_LOAD) &&
                  (seq_q == imrt_pkg::SQ_IDLE) &&
                  (fill_q < Fw'(imrt_pkg::WriteBufferDepth));

  always_comb begin
    logic scl, sda, dsend, adv;
    seq_d = seq_q; ph_d = ph_q; bit_d = bit_q; sh_d = sh_q; hp_d = hp_q;
    to_d = to_q; rem_d = rem_q; addr_d = addr_q; off_d = off_q; rd_d = rd_q;
    fill_d = fill_q; ridx_d = ridx_q; pend_d = pend_q; nak_d = nak_q;
    go = 1'b0; finish = 1'b0; fin_st = imrt_pkg::ST_OK;
    res_d = '0;
    scl = q_data_i.scl_in;
    sda = q_data_i.sda_in;
    dsend = 1'b0; adv = 1'b0;
    unique case (q_data_i.func)
      imrt_pkg::FUNC_TICK: begin
        unique case (seq_q)
          imrt_pkg::SQ_IDLE: ;
          imrt_pkg::SQ_FREE_WAIT: begin
            if (scl && sda) begin
              seq_d = imrt_pkg::SQ_FREE_COUNT; go = 1'b1;
            end else begin
              to_d = to_inc;
              if (to_inc >= cfg_i.stretch_timeout) begin
                finish = 1'b1; fin_st = imrt_pkg::ST_BUS_BUSY;
              end
            end
          end
          imrt_pkg::SQ_FREE_COUNT: begin
            if (!(scl && sda)) begin
              finish = 1'b1; fin_st = imrt_pkg::ST_BUS_BUSY;
            end else begin
              hp_d = hp_inc;
              if (hp_inc >= {8'd0, cfg_i.bus_free_ticks}) begin
                seq_d = imrt_pkg::SQ_START_HOLD; go = 1'b1;
              end
            end
          end
          imrt_pkg::SQ_START_HOLD: begin
            if (!scl) begin
              finish = 1'b1; fin_st = imrt_pkg::ST_BUS_BUSY;
            end else begin
              hp_d = hp_inc;
              if (half_done) begin
                sh_d = {addr_q, ph_q == imrt_pkg::PH_ADDR_R};
                bit_d = 4'd0; seq_d = imrt_pkg::SQ_TX_LOW; go = 1'b1;
              end
            end
          end
          imrt_pkg::SQ_TX_LOW, imrt_pkg::SQ_ACK_LOW, imrt_pkg::SQ_RX_LOW,
          imrt_pkg::SQ_MACK_LOW, imrt_pkg::SQ_STOP_LOW: begin
            hp_d = hp_inc;
            if (half_done) begin
              go = 1'b1;
              unique case (seq_q)
                imrt_pkg::SQ_TX_LOW:   seq_d = imrt_pkg::SQ_TX_RISE;
                imrt_pkg::SQ_ACK_LOW:  seq_d = imrt_pkg::SQ_ACK_RISE;
                imrt_pkg::SQ_RX_LOW:   seq_d = imrt_pkg::SQ_RX_RISE;
                imrt_pkg::SQ_MACK_LOW: seq_d = imrt_pkg::SQ_MACK_RISE;
                default:               seq_d = imrt_pkg::SQ_STOP_RISE;
              endcase
            end
          end
          imrt_pkg::SQ_TX_RISE: begin
            if (scl) begin
              if (sda != bitv) begin
                finish = 1'b1; fin_st = imrt_pkg::ST_ARB_LOST;
              end else begin
                seq_d = imrt_pkg::SQ_TX_HIGH; go = 1'b1;
              end
            end else begin
              to_d = to_inc;
              if (to_inc >= cfg_i.stretch_timeout) begin
                pend_d = imrt_pkg::ST_TIMEOUT; seq_d = imrt_pkg::SQ_STOP_LOW; go = 1'b1;
              end
            end
          end
          imrt_pkg::SQ_TX_HIGH: begin
            hp_d = hp_inc;
            if (half_done) begin
              sh_d = {sh_q[6:0], 1'b0};
              bit_d = bit_q + 4'd1;
              seq_d = (bit_q + 4'd1 >= 4'd8) ? imrt_pkg::SQ_ACK_LOW : imrt_pkg::SQ_TX_LOW;
              go = 1'b1;
            end
          end
          imrt_pkg::SQ_ACK_RISE: begin
            if (scl) begin
              nak_d = sda; seq_d = imrt_pkg::SQ_ACK_HIGH; go = 1'b1;
            end else begin
              to_d = to_inc;
              if (to_inc >= cfg_i.stretch_timeout) begin
                pend_d = imrt_pkg::ST_TIMEOUT; seq_d = imrt_pkg::SQ_STOP_LOW; go = 1'b1;
              end
            end
          end
          imrt_pkg::SQ_ACK_HIGH: begin
            hp_d = hp_inc;
            if (half_done) begin
              go = 1'b1;
              if (nak_q) begin
                pend_d = imrt_pkg::ST_NO_ACK; seq_d = imrt_pkg::SQ_STOP_LOW;
              end else begin
                unique case (ph_q)
                  imrt_pkg::PH_ADDR_W: begin
                    ph_d = imrt_pkg::PH_OFF_LO; sh_d = off_q[7:0];
                    bit_d = 4'd0; seq_d = imrt_pkg::SQ_TX_LOW;
                  end
                  imrt_pkg::PH_OFF_LO: begin
                    ph_d = imrt_pkg::PH_OFF_HI; sh_d = off_q[15:8];
                    bit_d = 4'd0; seq_d = imrt_pkg::SQ_TX_LOW;
                  end
                  imrt_pkg::PH_OFF_HI: begin
                    if (rd_q) begin
                      ph_d = imrt_pkg::PH_RESTART; pend_d = imrt_pkg::ST_OK;
                      seq_d = imrt_pkg::SQ_STOP_LOW;
                    end else begin
                      ph_d = imrt_pkg::PH_DATA; dsend = 1'b1;
                    end
                  end
                  imrt_pkg::PH_DATA: dsend = 1'b1;
                  imrt_pkg::PH_ADDR_R: begin
                    ph_d = imrt_pkg::PH_RX;
                    if (rem_q != 8'd0) begin
                      bit_d = 4'd0; sh_d = 8'd0; seq_d = imrt_pkg::SQ_RX_LOW;
                    end else begin
                      pend_d = imrt_pkg::ST_OK; seq_d = imrt_pkg::SQ_STOP_LOW;
                    end
                  end
                  default: begin
                    pend_d = imrt_pkg::ST_OK; seq_d = imrt_pkg::SQ_STOP_LOW;
                  end
                endcase
                if (dsend) begin
                  if (rem_q != 8'd0 && ridx_q < fill_q) begin
                    sh_d = ram_rd; ridx_d = ridx_q + Fw'(1);
                    rem_d = rem_q - 8'd1; bit_d = 4'd0; seq_d = imrt_pkg::SQ_TX_LOW;
                  end else begin
                    pend_d = imrt_pkg::ST_OK; seq_d = imrt_pkg::SQ_STOP_LOW;
                  end
                end
              end
            end
          end
          imrt_pkg::SQ_RX_RISE: begin
            if (scl) begin
              sh_d = {sh_q[6:0], sda};
              bit_d = bit_q + 4'd1;
              if (bit_q + 4'd1 >= 4'd8) begin
                res_d.read_valid = 1'b1;
                res_d.read_byte  = {sh_q[6:0], sda};
                res_d.read_last  = (rem_q <= 8'd1);
                if (rem_q != 8'd0) rem_d = rem_q - 8'd1;
              end
              seq_d = imrt_pkg::SQ_RX_HIGH; go = 1'b1;
            end else begin
              to_d = to_inc;
              if (to_inc >= cfg_i.receive_stretch_timeout) begin
                pend_d = imrt_pkg::ST_TIMEOUT; seq_d = imrt_pkg::SQ_STOP_LOW; go = 1'b1;
              end
            end
          end
          imrt_pkg::SQ_RX_HIGH: begin
            hp_d = hp_inc;
            if (half_done) begin
              go = 1'b1;
              seq_d = (bit_q >= 4'd8) ? imrt_pkg::SQ_MACK_LOW : imrt_pkg::SQ_RX_LOW;
            end
          end
          imrt_pkg::SQ_MACK_RISE, imrt_pkg::SQ_STOP_RISE: begin
            to_d = to_inc;
            if (scl || to_inc >= cfg_i.stretch_timeout) begin
              go = 1'b1;
              seq_d = (seq_q == imrt_pkg::SQ_MACK_RISE) ? imrt_pkg::SQ_MACK_HIGH :
                                                          imrt_pkg::SQ_STOP_HIGH;
            end
          end
          imrt_pkg::SQ_MACK_HIGH: begin
            hp_d = hp_inc;
            if (half_done) begin
              go = 1'b1;
              if (rem_q != 8'd0) begin
                bit_d = 4'd0; sh_d = 8'd0; seq_d = imrt_pkg::SQ_RX_LOW;
              end else begin
                pend_d = imrt_pkg::ST_OK; seq_d = imrt_pkg::SQ_STOP_LOW;
              end
            end
          end
          imrt_pkg::SQ_STOP_HIGH: begin
            hp_d = hp_inc;
            if (half_done) begin
              if (ph_q == imrt_pkg::PH_RESTART && pend_q == imrt_pkg::ST_OK) begin
                ph_d = imrt_pkg::PH_ADDR_R; seq_d = imrt_pkg::SQ_FREE_WAIT; go = 1'b1;
              end else begin
                finish = 1'b1; fin_st = pend_q;
              end
            end
          end
          default: begin
            seq_d = imrt_pkg::SQ_IDLE; go = 1'b1;
          end
        endcase
        adv = 1'b1;
      end
      imrt_pkg::FUNC_START: begin
        if (seq_q == imrt_pkg::SQ_IDLE) begin
          rd_d = q_data_i.is_read; addr_d = q_data_i.slave_addr;
          off_d = q_data_i.reg_offset; rem_d = q_data_i.byte_count;
          if (!cfg_i.enable) begin
            finish = 1'b1; fin_st = imrt_pkg::ST_DISABLED;
          end else if (!q_data_i.is_read &&
                       {{(Fw > 8 ? Fw - 8 : 0){1'b0}}, q_data_i.byte_count} >
                       {{(8 > Fw ? 8 - Fw : 0){1'b0}}, fill_q}) begin
            finish = 1'b1; fin_st = imrt_pkg::ST_BAD_LEN;
          end else begin
            ph_d = imrt_pkg::PH_ADDR_W; pend_d = imrt_pkg::ST_OK;
            ridx_d = '0; seq_d = imrt_pkg::SQ_FREE_WAIT; go = 1'b1;
          end
        end
      end
      imrt_pkg::FUNC_LOAD: begin
        if (ram_we) fill_d = fill_q + Fw'(1);
      end
      default: ;
    endcase
    if (finish) begin
      res_d.done_res = 1'b1;
      res_d.status = fin_st;
      if (!rd_d) begin
        fill_d = '0; ridx_d = '0;
      end
      seq_d = imrt_pkg::SQ_IDLE; go = 1'b1;
    end
    if (go) begin
      hp_d = '0; to_d = '0;
    end
    unique case (seq_q)
      imrt_pkg::SQ_START_HOLD: res_d.sda_drive_low = 1'b1;
      imrt_pkg::SQ_TX_LOW: begin
        res_d.scl_drive_low = 1'b1; res_d.sda_drive_low = !sh_d[7];
      end
      default: ;
    endcase
    unique case (seq_d)
      imrt_pkg::SQ_START_HOLD: begin
        res_d.scl_drive_low = 1'b0; res_d.sda_drive_low = 1'b1;
      end
      imrt_pkg::SQ_TX_LOW: begin
        res_d.scl_drive_low = 1'b1; res_d.sda_drive_low = !sh_d[7];
      end
      imrt_pkg::SQ_TX_RISE, imrt_pkg::SQ_TX_HIGH: begin
        res_d.scl_drive_low = 1'b0; res_d.sda_drive_low = !sh_d[7];
      end
      imrt_pkg::SQ_ACK_LOW, imrt_pkg::SQ_RX_LOW: begin
        res_d.scl_drive_low = 1'b1; res_d.sda_drive_low = 1'b0;
      end
      imrt_pkg::SQ_MACK_LOW: begin
        res_d.scl_drive_low = 1'b1; res_d.sda_drive_low = (rem_d != 8'd0);
      end
      imrt_pkg::SQ_MACK_RISE, imrt_pkg::SQ_MACK_HIGH: begin
        res_d.scl_drive_low = 1'b0; res_d.sda_drive_low = (rem_d != 8'd0);
      end
      imrt_pkg::SQ_STOP_LOW: begin
        res_d.scl_drive_low = 1'b1; res_d.sda_drive_low = 1'b1;
      end
      imrt_pkg::SQ_STOP_RISE, imrt_pkg::SQ_STOP_HIGH: begin
        res_d.scl_drive_low = 1'b0; res_d.sda_drive_low = 1'b1;
      end
      default: begin
        res_d.scl_drive_low = 1'b0; res_d.sda_drive_low = 1'b0;
      end
    endcase
    res_d.busy_res = (seq_d != imrt_pkg::SQ_IDLE);
    if (!adv) begin
      bit_d = bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= imrt_pkg::SQ_IDLE; ph_q <= imrt_pkg::PH_ADDR_W;
      bit_q <= '0; sh_q <= '0; hp_q <= '0; to_q <= '0; rem_q <= '0;
      addr_q <= '0; off_q <= '0; rd_q <= 1'b0; fill_q <= '0; ridx_q <= '0;
      pend_q <= imrt_pkg::ST_OK; nak_q <= 1'b0; outv_q <= 1'b0;
    end else begin
      if (step) begin
        seq_q <= seq_d; ph_q <= ph_d; bit_q <= bit_d; sh_q <= sh_d;
        hp_q <= hp_d; to_q <= to_d; rem_q <= rem_d; addr_q <= addr_d;
        off_q <= off_d; rd_q <= rd_d; fill_q <= fill_d; ridx_q <= ridx_d;
        pend_q <= pend_d; nak_q <= nak_d;
      end
      if (step) begin
        outv_q <= 1'b1;
      end else if (out_ready_i) begin
        outv_q <= 1'b0;
      end
    end
  end

endmodule

// ----- design/i2c_master_register_transfer.sv -----
// One word per cycle while the output is accepted; each result passes
// the front queue slot and the engine result register. The bus engine
// steps once per word. Reset clears the queue, sequencer, counters and
// buffer fill; the write buffer contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// I2C register transfer master
// Open-drain I2C master for register reads and writes with a 16-bit offset.
// ----------------------------------------------------------------------------
`include "i2c_master_register_transfer_assert.svh"

module i2c_master_register_transfer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  imrt_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imrt_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  imrt_pkg::cfg_t     cfg_q;
  logic               q_valid, q_ready;
  imrt_pkg::in_word_t q_data;
  logic               wr;
  imrt_pkg::reg_e     ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = imrt_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable                  <= 1'b0;
      cfg_q.half_period_ticks       <= 16'd4;
      cfg_q.stretch_timeout         <= 16'd20000;
      cfg_q.receive_stretch_timeout <= 16'd256;
      cfg_q.bus_free_ticks          <= 8'd50;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        imrt_pkg::REG_ENABLE:   cfg_q.enable <= pwdata[0];
        imrt_pkg::REG_HALF:     cfg_q.half_period_ticks <= pwdata[15:0];
        imrt_pkg::REG_STRETCH:  cfg_q.stretch_timeout <= pwdata[15:0];
        imrt_pkg::REG_RSTRETCH: cfg_q.receive_stretch_timeout <= pwdata[15:0];
        imrt_pkg::REG_FREE:     cfg_q.bus_free_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      imrt_pkg::REG_ENABLE:   prdata = {31'd0, cfg_q.enable};
      imrt_pkg::REG_HALF:     prdata = {16'd0, cfg_q.half_period_ticks};
      imrt_pkg::REG_STRETCH:  prdata = {16'd0, cfg_q.stretch_timeout};
      imrt_pkg::REG_RSTRETCH: prdata = {16'd0, cfg_q.receive_stretch_timeout};
      imrt_pkg::REG_FREE:     prdata = {24'd0, cfg_q.bus_free_ticks};
      default:                prdata = 32'd0;
    endcase
  end

  imrt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  imrt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `IMRT_ASSERT(a_status_only_done, clk_i, rst_ni,
    !out_valid_o || out_data_o.done_res || out_data_o.status == 3'd0)
  `IMRT_ASSERT(a_last_needs_valid, clk_i, rst_ni,
    !out_valid_o || out_data_o.read_valid || !out_data_o.read_last)
  `IMRT_ASSERT_NEXT(a_step_gives_out, clk_i, rst_ni, q_valid && q_ready, out_valid_o)

endmodule

// ----- verif/imrt_checker.sv -----
// ----------------------------------------------------------------------------
// I2C register transfer result checker
// Watches the word channels and the register port, runs its own cycle model
// of the bus sequencer on every accepted input word and compares each
// accepted output word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module imrt_checker
  import imrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  logic        en;
  int unsigned half_ticks, stretch_ticks, rx_stretch_ticks, free_ticks;

  seq_e        sq;
  phase_e      ph;
  status_e     pend_st;
  int unsigned hp_cnt, to_cnt, fill, rd_idx;
  logic [3:0]  bitc;
  logic [7:0]  shreg, bytes_rem;
  logic [6:0]  addr_l;
  logic [15:0] off_l;
  logic        rd_l, ack_missing;
  logic [7:0]  wbuf [WriteBufferDepth];

  logic        ev_done, ev_valid, ev_last;
  logic [2:0]  ev_status;
  logic [7:0]  ev_byte;

  out_word_t   predicted_q [$];

  function automatic void goto_state(seq_e s);
    sq = s;
    hp_cnt = 0;
    to_cnt = 0;
  endfunction

  function automatic bit half_done();
    hp_cnt++;
    return hp_cnt >= half_ticks;
  endfunction

  function automatic bit waited(int unsigned limit);
    to_cnt++;
    return to_cnt >= limit;
  endfunction

  function automatic void end_transfer(status_e st);
    ev_done = 1'b1;
    ev_status = st;
    if (!rd_l) begin
      fill = 0;
      rd_idx = 0;
    end
    goto_state(SQ_IDLE);
  endfunction

  function automatic void start_stop(status_e st);
    pend_st = st;
    goto_state(SQ_STOP_LOW);
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shreg = b;
    bitc = 0;
    goto_state(SQ_TX_LOW);
  endfunction

  function automatic void next_data_or_stop();
    if (bytes_rem > 0 && rd_idx < fill && rd_idx < WriteBufferDepth) begin
      load_byte(wbuf[rd_idx]);
      rd_idx++;
      bytes_rem--;
    end else begin
      start_stop(ST_OK);
    end
  endfunction

  function automatic void acked();
    case (ph)
      PH_ADDR_W: begin
        ph = PH_OFF_LO;
        load_byte(off_l[7:0]);
      end
      PH_OFF_LO: begin
        ph = PH_OFF_HI;
        load_byte(off_l[15:8]);
      end
      PH_OFF_HI: begin
        if (rd_l) begin
          ph = PH_RESTART;
          start_stop(ST_OK);
        end else begin
          ph = PH_DATA;
          next_data_or_stop();
        end
      end
      PH_DATA: next_data_or_stop();
      PH_ADDR_R: begin
        ph = PH_RX;
        if (bytes_rem > 0) begin
          bitc = 0;
          shreg = 0;
          goto_state(SQ_RX_LOW);
        end else begin
          start_stop(ST_OK);
        end
      end
      default: start_stop(ST_OK);
    endcase
  endfunction

  function automatic void bus_tick(logic scl, logic sda);
    logic b;
    b = shreg[7];
    case (sq)
      SQ_IDLE: ;
      SQ_FREE_WAIT: begin
        if (scl && sda) goto_state(SQ_FREE_COUNT);
        else if (waited(stretch_ticks)) end_transfer(ST_BUS_BUSY);
      end
      SQ_FREE_COUNT: begin
        if (!(scl && sda)) begin
          end_transfer(ST_BUS_BUSY);
        end else begin
          hp_cnt++;
          if (hp_cnt >= free_ticks) goto_state(SQ_START_HOLD);
        end
      end
      SQ_START_HOLD: begin
        if (!scl) end_transfer(ST_BUS_BUSY);
        else if (half_done()) load_byte({addr_l, ph == PH_ADDR_R});
      end
      SQ_TX_LOW: if (half_done()) goto_state(SQ_TX_RISE);
      SQ_TX_RISE: begin
        if (scl) begin
          if (sda != b) end_transfer(ST_ARB_LOST);
          else goto_state(SQ_TX_HIGH);
        end else if (waited(stretch_ticks)) begin
          start_stop(ST_TIMEOUT);
        end
      end
      SQ_TX_HIGH: begin
        if (half_done()) begin
          shreg = shreg << 1;
          bitc++;
          goto_state(bitc >= 8 ? SQ_ACK_LOW : SQ_TX_LOW);
        end
      end
      SQ_ACK_LOW: if (half_done()) goto_state(SQ_ACK_RISE);
      SQ_ACK_RISE: begin
        if (scl) begin
          ack_missing = sda;
          goto_state(SQ_ACK_HIGH);
        end else if (waited(stretch_ticks)) begin
          start_stop(ST_TIMEOUT);
        end
      end
      SQ_ACK_HIGH: begin
        if (half_done()) begin
          if (ack_missing) start_stop(ST_NO_ACK);
          else acked();
        end
      end
      SQ_RX_LOW: if (half_done()) goto_state(SQ_RX_RISE);
      SQ_RX_RISE: begin
        if (scl) begin
          shreg = {shreg[6:0], sda};
          bitc++;
          if (bitc >= 8) begin
            ev_valid = 1'b1;
            ev_byte = shreg;
            ev_last = bytes_rem <= 1;
            if (bytes_rem > 0) bytes_rem--;
          end
          goto_state(SQ_RX_HIGH);
        end else if (waited(rx_stretch_ticks)) begin
          start_stop(ST_TIMEOUT);
        end
      end
      SQ_RX_HIGH: if (half_done()) goto_state(bitc >= 8 ? SQ_MACK_LOW : SQ_RX_LOW);
      SQ_MACK_LOW: if (half_done()) goto_state(SQ_MACK_RISE);
      SQ_MACK_RISE: if (scl || waited(stretch_ticks)) goto_state(SQ_MACK_HIGH);
      SQ_MACK_HIGH: begin
        if (half_done()) begin
          if (bytes_rem > 0) begin
            bitc = 0;
            shreg = 0;
            goto_state(SQ_RX_LOW);
          end else begin
            start_stop(ST_OK);
          end
        end
      end
      SQ_STOP_LOW: if (half_done()) goto_state(SQ_STOP_RISE);
      SQ_STOP_RISE: if (scl || waited(stretch_ticks)) goto_state(SQ_STOP_HIGH);
      SQ_STOP_HIGH: begin
        if (half_done()) begin
          if (ph == PH_RESTART && pend_st == ST_OK) begin
            ph = PH_ADDR_R;
            goto_state(SQ_FREE_WAIT);
          end else begin
            end_transfer(pend_st);
          end
        end
      end
      default: goto_state(SQ_IDLE);
    endcase
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    logic      b;
    ev_done = 0;
    ev_status = ST_OK;
    ev_valid = 0;
    ev_byte = 0;
    ev_last = 0;
    if (w.func == FUNC_TICK) begin
      bus_tick(w.scl_in, w.sda_in);
    end else if (w.func == FUNC_START && sq == SQ_IDLE) begin
      rd_l = w.is_read;
      addr_l = w.slave_addr;
      off_l = w.reg_offset;
      bytes_rem = w.byte_count;
      if (!en) begin
        end_transfer(ST_DISABLED);
      end else if (!rd_l && bytes_rem > fill) begin
        end_transfer(ST_BAD_LEN);
      end else begin
        ph = PH_ADDR_W;
        pend_st = ST_OK;
        rd_idx = 0;
        goto_state(SQ_FREE_WAIT);
      end
    end else if (w.func == FUNC_LOAD && sq == SQ_IDLE && fill < WriteBufferDepth) begin
      wbuf[fill] = w.write_byte;
      fill++;
    end
    r = '0;
    b = shreg[7];
    case (sq)
      SQ_START_HOLD: r.sda_drive_low = 1'b1;
      SQ_TX_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = !b;
      end
      SQ_TX_RISE, SQ_TX_HIGH: r.sda_drive_low = !b;
      SQ_ACK_LOW, SQ_RX_LOW: r.scl_drive_low = 1'b1;
      SQ_MACK_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = bytes_rem > 0;
      end
      SQ_MACK_RISE, SQ_MACK_HIGH: r.sda_drive_low = bytes_rem > 0;
      SQ_STOP_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = 1'b1;
      end
      SQ_STOP_RISE, SQ_STOP_HIGH: r.sda_drive_low = 1'b1;
      default: ;
    endcase
    r.busy_res = sq != SQ_IDLE;
    r.read_byte = ev_byte;
    r.read_valid = ev_valid;
    r.read_last = ev_last;
    r.done_res = ev_done;
    r.status = ev_status;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    out_word_t got_w;
    if (!rst_ni) begin
      en = 0;
      half_ticks = 4;
      stretch_ticks = 20000;
      rx_stretch_ticks = 256;
      free_ticks = 50;
      goto_state(SQ_IDLE);
      bitc = 0;
      shreg = 0;
      bytes_rem = 0;
      addr_l = 0;
      off_l = 0;
      rd_l = 0;
      fill = 0;
      rd_idx = 0;
      ph = PH_ADDR_W;
      pend_st = ST_OK;
      ack_missing = 0;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:2]))
          REG_ENABLE:   en = pwdata[0];
          REG_HALF:     half_ticks = pwdata[15:0];
          REG_STRETCH:  stretch_ticks = pwdata[15:0];
          REG_RSTRETCH: rx_stretch_ticks = pwdata[15:0];
          REG_FREE:     free_ticks = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_w = out_data_i;
        if (predicted_q.size() == 0) begin
          $error("output word with no prediction waiting: %0h", got_w);
          fail_count_o++;
        end else begin
          exp_w = predicted_q.pop_front();
          compare_field("scl_drive_low", exp_w.scl_drive_low, got_w.scl_drive_low);
          compare_field("sda_drive_low", exp_w.sda_drive_low, got_w.sda_drive_low);
          compare_field("busy_res", exp_w.busy_res, got_w.busy_res);
          compare_field("read_byte", exp_w.read_byte, got_w.read_byte);
          compare_field("read_valid", exp_w.read_valid, got_w.read_valid);
          compare_field("read_last", exp_w.read_last, got_w.read_last);
          compare_field("done_res", exp_w.done_res, got_w.done_res);
          compare_field("status", exp_w.status, got_w.status);
        end
      end
      if (in_valid_i && in_ready_i) predicted_q.push_back(predict_word(in_data_i));
      pending_o = predicted_q.size();
    end
  end

endmodule

// ----- verif/tb_i2c_master_register_transfer.sv -----
// ----------------------------------------------------------------------------
// I2C register transfer master testbench
// Drives register reads and writes through the word channel while a small
// bus-side device model answers each tick from the pin drives last seen,
// across several register settings, with random idling, long output
// stalls and noise words. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_transfer;
  import imrt_pkg::*;

  localparam int unsigned IdleLimit = 4000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_word_t    in_data_i;
  out_word_t   out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;

  int unsigned sent_words, seen_words, phase_words;
  logic        drv_scl, drv_sda, seen_busy;
  int          pulse, starts_seen, byte_idx, noise_pct, stretch_left, hold_left;
  bit          nak_now, txn_read, quiet, hold_req;

  i2c_master_register_transfer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  imrt_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = quiet || ($urandom_range(0, 99) >= 22);
    end
  end

  // Bus-side device: follows START and clock pulses from the observed drives.
  always @(posedge clk_i) begin
    out_word_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r = out_data_o;
      seen_words++;
      if (!drv_scl && !drv_sda && !r.scl_drive_low && r.sda_drive_low) begin
        starts_seen++;
        pulse = 0;
        byte_idx = 0;
      end
      if (!drv_scl && r.scl_drive_low) begin
        if (pulse >= 9) begin
          pulse = 1;
          byte_idx++;
        end else begin
          pulse++;
        end
        if (pulse == 9) nak_now = $urandom_range(0, 99) < 4;
      end
      drv_scl = r.scl_drive_low;
      drv_sda = r.sda_drive_low;
      seen_busy = r.busy_res;
    end
  end

  initial begin
    while (IdleLimit > 0) begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IdleLimit) begin
        @(posedge clk_i);
        if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
        else quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_word_t random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    bit       rx_data;
    w = random_word();
    w.func = FUNC_TICK;
    w.scl_in = !drv_scl;
    w.sda_in = !drv_sda;
    rx_data = txn_read && starts_seen == 2 && byte_idx >= 1;
    if (rx_data && pulse >= 1 && pulse <= 8) w.sda_in = $urandom_range(0, 1);
    else if (!rx_data && starts_seen > 0 && pulse == 9) w.sda_in = nak_now;
    if ($urandom_range(0, 99) < noise_pct) w.sda_in = !w.sda_in;
    if (stretch_left > 0) begin
      w.scl_in = 1'b0;
      stretch_left--;
    end else if ($urandom_range(0, 199) == 0) begin
      stretch_left = $urandom_range(1, 6);
    end
    return w;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w = random_word();
    w.byte_count = $urandom_range(0, 3);
    return w;
  endfunction

  // Paced words wait for their own result so the device answers current drives.
  task automatic send_word(in_word_t w, bit paced);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    do @(posedge clk_i); while (!in_ready_o);
    sent_words++;
    phase_words++;
    if (paced) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      while (sent_words != seen_words) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sent_words != seen_words) @(posedge clk_i);
    while (seen_busy) send_word(tick_word(), 1);
  endtask

  task automatic run_transfer(bit rd, int nloads, int cnt);
    in_word_t w;
    repeat (nloads) begin
      w = random_word();
      w.func = FUNC_LOAD;
      send_word(w, 1);
    end
    txn_read = rd;
    starts_seen = 0;
    pulse = 0;
    byte_idx = 0;
    w = random_word();
    w.func = FUNC_START;
    w.is_read = rd;
    w.byte_count = cnt;
    send_word(w, 1);
    while (seen_busy) send_word(tick_word(), 1);
  endtask

  task automatic apb_write(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(bit en, int half, int st, int rst_to, int free);
    settle();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    apb_write(REG_ENABLE, en);
    apb_write(REG_HALF, half);
    apb_write(REG_STRETCH, st);
    apb_write(REG_RSTRETCH, rst_to);
    apb_write(REG_FREE, free);
  endtask

  task automatic run_phase(int budget, bit pressure);
    bit rd;
    int nl, cnt;
    phase_words = 0;
    if (pressure) begin
      @(posedge clk_i);
      hold_req = 1;
      repeat (40) send_word(noise_word(), 0);
      settle();
    end
    while (phase_words < budget) begin
      rd = $urandom_range(0, 1);
      nl = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 5);
      if (rd) cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      else if ($urandom_range(0, 9) == 0) cnt = $urandom_range(128, 255);
      else cnt = $urandom_range(0, nl > 32 ? 32 : nl);
      run_transfer(rd, nl, cnt);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(2, 8)) send_word(noise_word(), 0);
        settle();
      end
    end
  endtask

  initial begin
    in_word_t w;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent_words = 0;
    seen_words = 0;
    drv_scl = 1'b0;
    drv_sda = 1'b0;
    seen_busy = 1'b0;
    pulse = 0;
    starts_seen = 0;
    byte_idx = 0;
    noise_pct = 1;
    stretch_left = 0;
    hold_left = 0;
    hold_req = 0;
    nak_now = 0;
    txn_read = 0;
    quiet = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Disabled block: idle ticks, the unused code, loads and refused starts.
    w = '0;
    send_word(w, 1);
    w = '1;
    w.func = FUNC_TICK;
    send_word(w, 1);
    w.func = FUNC_NONE;
    send_word(w, 1);
    w = '0;
    w.func = FUNC_LOAD;
    send_word(w, 1);
    w.write_byte = 8'hff;
    send_word(w, 1);
    w = '1;
    w.func = FUNC_START;
    send_word(w, 1);
    w = '0;
    w.func = FUNC_START;
    send_word(w, 1);

    set_config(1, 1, 300, 300, 1);
    w = '0;
    w.func = FUNC_START;
    w.byte_count = 8'd1;
    send_word(w, 1);
    run_transfer(0, 2, 2);
    run_transfer(1, 0, 0);
    run_transfer(0, 0, 0);
    run_transfer(1, 0, 2);
    run_transfer(0, 34, 32);
    run_phase(300, 0);

    quiet = 1;
    set_config(1, 2, 65535, 65535, 255);
    run_phase(400, 0);
    quiet = 0;

    set_config(1, 3, 1, 1, 3);
    run_phase(250, 0);

    set_config(1, 1, 20, 5, 2);
    run_phase(250, 1);

    noise_pct = 100;
    set_config(1, 65535, 1, 1, 1);
    run_phase(30, 0);
    noise_pct = 1;

    set_config(0, 2, 100, 100, 4);
    run_phase(30, 0);

    set_config(1, 2, 500, 200, 6);
    run_phase(200, 1);

    settle();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/imrt_pkg.sv
design/imrt_ram.sv
design/imrt_front.sv
design/imrt_engine.sv
design/i2c_master_register_transfer.sv
verif/imrt_checker.sv
verif/tb_i2c_master_register_transfer.sv
